// File: src/rws_pkg.sv
// Shared types and constants for the roulette wheel selector.
`default_nettype none

package rws_pkg;

	// Table geometry.
	localparam int MAX_POP  = 64;
	localparam int IDX_W    = $clog2(MAX_POP);
	localparam int CNT_W    = $clog2(MAX_POP + 1);
	localparam int FIT_W    = 16;
	localparam int DRAW_W   = 16;
	localparam int PREFIX_W = 22;
	localparam int TARGET_W = PREFIX_W + DRAW_W;
	localparam int POP_W    = 7;
	localparam int STAT_W   = 2;

	// Reset value of the population size register.
	localparam logic [POP_W-1:0] POP_RESET = POP_W'(64);

	// Request codes.
	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_SELECT = 1'b1;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ZERO_TOTAL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_LOADED = 2'd2;

	// Input item.
	typedef struct packed {
		logic              req_type;
		logic              first;
		logic [FIT_W-1:0]  fitness;
		logic [DRAW_W-1:0] random_draw;
	} in_item_t;

	// Result item.
	typedef struct packed {
		logic [IDX_W-1:0]  selected_index;
		logic [STAT_W-1:0] status;
	} out_item_t;

	// Token that walks down the chain of cells. In fetch mode acc picks up the
	// total; in search mode acc holds the scaled target.
	typedef struct packed {
		logic                valid;
		logic                search;
		logic                found;
		logic [IDX_W-1:0]    idx;
		logic [TARGET_W-1:0] acc;
	} tok_t;

endpackage

`default_nettype wire

// File: src/rws_cell.sv
// One cell of the selector chain: holds one cumulative sum and forwards the token.
`default_nettype none

module rws_cell import rws_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [IDX_W-1:0]    cell_idx,
	input  wire logic [IDX_W-1:0]    last_idx,
	input  wire logic                wr_en,
	input  wire logic [PREFIX_W-1:0] wr_data,
	input  wire tok_t                tok_in,
	output tok_t                     tok_out
);

	logic [PREFIX_W-1:0] prefix_q;
	logic [TARGET_W-1:0] scaled;
	tok_t                tok_nxt;
	tok_t                pay_q;
	logic                vld_q;

	// Stored cumulative sum, written when the top level appends this entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			prefix_q <= wr_data;
		end
	end

	// Prefix times 65535, formed as a shift and a subtract.
	assign scaled = {prefix_q, DRAW_W'(0)} - TARGET_W'(prefix_q);

	// Fetch picks up the total at the last live entry; search marks the first hit.
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.search) begin
			if (!tok_in.found && (scaled >= tok_in.acc)) begin
				tok_nxt.found = 1'b1;
				tok_nxt.idx   = cell_idx;
			end
		end else if (cell_idx == last_idx) begin
			tok_nxt.acc = TARGET_W'(prefix_q);
		end
	end

	// Token valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= tok_in.valid;
		end
	end

	// Token payload.
	always_ff @(posedge clk) begin
		pay_q <= tok_nxt;
	end

	always_comb begin
		tok_out       = pay_q;
		tok_out.valid = vld_q;
	end

endmodule

`default_nettype wire

// File: src/roulette_wheel_selector.sv
// Top level of the roulette wheel selector: control, loading and the cell chain.
//
// Channel   Direction  Handshake                    Payload
// in        input      in_valid / in_ready          in_item  (in_item_t)
// out       output     out_valid / out_ready        out_item (out_item_t)
// config    input      psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// A load item gives no result.
// A select item sends a token down the chain of cells once to fetch the total and,
// unless the total is zero, once more to search; one cell per cycle.
// A select before the population is complete skips the chain and goes straight to the finishing state.
// One item is processed at a time; a new item is accepted while a result waits.
// Reset clears counts, the total and all token valid bits; table entries are unwritten.
`default_nettype none

module roulette_wheel_selector import rws_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_FETCH  = 5'b00010,
		ST_MUL    = 5'b00100,
		ST_SEARCH = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t              state_q;
	logic [POP_W-1:0]    pop_size_q;
	logic [CNT_W-1:0]    loaded_count_q;
	logic [PREFIX_W-1:0] running_total_q;
	logic [DRAW_W-1:0]   draw_q;
	logic [TARGET_W-1:0] prod_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic [STAT_W-1:0]   res_status_q;
	logic                inj_vld_q;
	tok_t                inj_pay_q;
	logic                out_valid_q;
	out_item_t           out_item_q;

	logic [CNT_W-1:0]    n_eff;
	logic [IDX_W-1:0]    last_idx;
	logic                sel_fire;
	logic                load_fire;
	logic                not_loaded;
	logic [CNT_W-1:0]    load_cnt;
	logic [PREFIX_W-1:0] load_base;
	logic [PREFIX_W:0]   load_sum;
	logic [PREFIX_W-1:0] load_sat;
	logic                load_ok;
	logic                cfg_wr;
	logic                out_free;
	logic                fetch_done;
	logic                search_done;
	logic [PREFIX_W-1:0] total;
	tok_t                chain [MAX_POP+1];
	logic [MAX_POP-1:0]  wr_en;

	// Configuration port: one register, always ready.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : 32'(pop_size_q);

	// Effective population size, held within two and the table depth.
	always_comb begin
		if (pop_size_q < POP_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (CNT_W'(pop_size_q) > CNT_W'(MAX_POP)) begin
			n_eff = CNT_W'(MAX_POP);
		end else begin
			n_eff = CNT_W'(pop_size_q);
		end
	end
	assign last_idx = IDX_W'(n_eff - CNT_W'(1));

	// Handshake decode.
	assign in_ready   = (state_q == ST_IDLE);
	assign sel_fire   = in_valid && in_ready && (in_item.req_type == REQ_SELECT);
	assign load_fire  = in_valid && in_ready && (in_item.req_type == REQ_LOAD);
	assign not_loaded = loaded_count_q < n_eff;
	assign out_free   = !out_valid_q || out_ready;

	// Append logic: a new population restarts the count and the running sum.
	assign load_cnt  = in_item.first ? '0 : loaded_count_q;
	assign load_base = in_item.first ? '0 : running_total_q;
	assign load_sum  = {1'b0, load_base} + (PREFIX_W+1)'(in_item.fitness);
	assign load_sat  = load_sum[PREFIX_W] ? {PREFIX_W{1'b1}} : load_sum[PREFIX_W-1:0];
	assign load_ok   = load_fire && (load_cnt < n_eff);

	// Token leaving the end of the chain.
	assign fetch_done  = (state_q == ST_FETCH) && chain[MAX_POP].valid;
	assign search_done = (state_q == ST_SEARCH) && chain[MAX_POP].valid;
	assign total       = chain[MAX_POP].acc[PREFIX_W-1:0];

	// Injected token enters the first cell.
	always_comb begin
		chain[0]       = inj_pay_q;
		chain[0].valid = inj_vld_q;
	end

	// Row of cells, each written when its entry is appended.
	for (genvar i = 0; i < MAX_POP; i++) begin : g_cell
		assign wr_en[i] = load_ok && (load_cnt == CNT_W'(i));

		rws_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(i)),
			.last_idx (last_idx),
			.wr_en    (wr_en[i]),
			.wr_data  (load_sat),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	// Control state, counters and the configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			pop_size_q      <= POP_RESET;
			loaded_count_q  <= '0;
			running_total_q <= '0;
			inj_vld_q       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			inj_vld_q <= 1'b0;
			if (cfg_wr) begin
				pop_size_q <= pwdata[POP_W-1:0];
			end
			if (load_ok) begin
				running_total_q <= load_sat;
				loaded_count_q  <= load_cnt + CNT_W'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sel_fire) begin
						state_q   <= not_loaded ? ST_DONE : ST_FETCH;
						inj_vld_q <= !not_loaded;
					end
				end
				ST_FETCH: begin
					if (fetch_done) begin
						state_q <= (total == '0) ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q   <= ST_SEARCH;
					inj_vld_q <= 1'b1;
				end
				ST_SEARCH: begin
					if (search_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: draw, target, token contents and the result.
	always_ff @(posedge clk) begin
		if (sel_fire) begin
			draw_q       <= in_item.random_draw;
			res_idx_q    <= '0;
			res_status_q <= not_loaded ? STAT_NOT_LOADED : STAT_OK;
			inj_pay_q    <= '{valid: 1'b1, search: 1'b0, found: 1'b0, idx: '0, acc: '0};
		end
		if (fetch_done) begin
			prod_q <= TARGET_W'(draw_q) * TARGET_W'(total);
			if (total == '0) begin
				res_status_q <= STAT_ZERO_TOTAL;
			end
		end
		if (state_q == ST_MUL) begin
			inj_pay_q <= '{valid: 1'b1, search: 1'b1, found: 1'b0, idx: '0, acc: prod_q};
		end
		if (search_done) begin
			res_idx_q <= chain[MAX_POP].idx;
		end
		if (state_q == ST_DONE && out_free) begin
			out_item_q <= '{selected_index: res_idx_q, status: res_status_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// A result that is not ok carries index zero.
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.status != STAT_OK) |-> out_item_q.selected_index == '0)
		else $error("non-ok result carries a nonzero index");

	// No token leaves the chain while the block is idle.
	a_no_stray_tok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !chain[MAX_POP].valid)
		else $error("token left the chain while idle");

	// A result appears only after the finishing state.
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the finishing state");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for the roulette wheel selector: scoreboard with its own predictor, stimulus and checks.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rws_pkg::*;

	localparam int unsigned ITEM_GOAL      = 2000;
	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned DRAIN_CYCLES   = 2 * MAX_POP + 16;
	localparam longint unsigned LIMIT_NS   = 64'd20_000_000;
	localparam longint unsigned DRAW_FULL  = (64'd1 << DRAW_W) - 1;
	localparam logic [PREFIX_W:0] PREFIX_MAX = {1'b0, {PREFIX_W{1'b1}}};
	localparam logic [2:0] ADDR_POP_SIZE   = 3'd0;

	// Shapes of the fitness values in one generation.
	typedef enum int unsigned {FIT_SMALL, FIT_HIGH, FIT_ZERO, FIT_FULL} fit_style_e;

	// Shapes of one load sequence; all but the last are broken on purpose.
	typedef enum int unsigned {SEQ_SHORT, SEQ_LONG, SEQ_NO_FIRST, SEQ_CLEAN} seq_shape_e;

	// Tracks the cumulative table and the queue of selections still to come out.
	class wheel_tracker;
		bit [PREFIX_W-1:0] prefix_sums [MAX_POP];
		bit [PREFIX_W-1:0] running_sum = '0;
		int unsigned       filled      = 0;
		bit [POP_W-1:0]    pop_reg     = POP_RESET;
		out_item_t         picks_due [$];
		int unsigned       errors      = 0;
		int unsigned       accepted    = 0;
		int unsigned       loads       = 0;
		int unsigned       picks_ok    = 0;
		int unsigned       picks_zero  = 0;
		int unsigned       picks_short = 0;
		int unsigned       pop_writes  = 0;

		// The register value saturated into the usable range.
		function int unsigned pop_in_use();
			int unsigned n;
			n = pop_reg;
			if (n < 2) n = 2;
			if (n > MAX_POP) n = MAX_POP;
			return n;
		endfunction

		function void set_pop(bit [POP_W-1:0] value);
			pop_reg = value;
			pop_writes++;
		endfunction

		// Spins the wheel: first index whose prefix reaches draw/65535 of the total.
		function out_item_t spin(bit [DRAW_W-1:0] draw);
			out_item_t       res;
			int unsigned     n;
			longint unsigned total;
			longint unsigned target;
			bit              found;
			n = pop_in_use();
			found = 1'b0;
			res.selected_index = '0;
			res.status = STAT_OK;
			if (filled < n) begin
				res.status = STAT_NOT_LOADED;
			end else begin
				total = prefix_sums[n-1];
				if (total == 0) begin
					res.status = STAT_ZERO_TOTAL;
				end else begin
					target = draw * total;
					res.selected_index = IDX_W'(n - 1);
					for (int k = 0; k < n && !found; k++) begin
						if (prefix_sums[k] * DRAW_FULL >= target) begin
							res.selected_index = IDX_W'(k);
							found = 1'b1;
						end
					end
				end
			end
			return res;
		endfunction

		// Updates the table for an accepted item and queues the selection it causes.
		function void note_item(in_item_t it);
			out_item_t         due;
			bit [PREFIX_W:0]   sum;
			int unsigned       n;
			n = pop_in_use();
			accepted++;
			if (it.req_type == REQ_LOAD) begin
				if (it.first) begin
					running_sum = '0;
					filled = 0;
				end
				// Loads past the end of the population are dropped.
				if (filled < n) begin
					sum = running_sum + it.fitness;
					if (sum > PREFIX_MAX) sum = PREFIX_MAX;
					running_sum = sum[PREFIX_W-1:0];
					prefix_sums[filled] = sum[PREFIX_W-1:0];
					filled++;
					loads++;
				end
			end else begin
				due = spin(it.random_draw);
				picks_due = {picks_due, due};
				if (due.status == STAT_OK) picks_ok++;
				else if (due.status == STAT_ZERO_TOTAL) picks_zero++;
				else picks_short++;
			end
		endfunction

		// Compares one result with the oldest selection waiting.
		function void check_pick(out_item_t got);
			out_item_t due;
			if (picks_due.size() == 0) begin
				$error("Result with no select waiting: selected_index %0d, status %0d",
					got.selected_index, got.status);
				errors++;
				return;
			end
			due = picks_due.pop_front();
			if (got.selected_index !== due.selected_index) begin
				$error("selected_index mismatch: expected %0d, actual %0d",
					due.selected_index, got.selected_index);
				errors++;
			end
			if (got.status !== due.status) begin
				$error("status mismatch: expected %0d, actual %0d", due.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_item;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	wheel_tracker tracker = new;
	bit           calm       = 1'b0;
	bit           tx_bursts  = 1'b1;
	bit           rx_bursts  = 1'b1;
	int unsigned  calm_mark  = 32'hFFFF_FFFF;

	roulette_wheel_selector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#(LIMIT_NS);
		$display("Timeout: the run did not finish in time");
		$display("Test completed with failures");
		$finish;
	end

	// Both handshakes are observed at the clock edge.
	always @(posedge clk) begin
		if (in_valid && in_ready) tracker.note_item(in_item);
		if (out_valid && out_ready) tracker.check_pick(out_item);
	end

	// Result side: stalls in bursts, with long stretches of none.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 299) == 0) rx_bursts = !rx_bursts;
			if (!calm && rx_bursts && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic in_item_t pack_item(logic req, logic lead, logic [FIT_W-1:0] fit,
			logic [DRAW_W-1:0] draw);
		in_item_t it;
		it.req_type = req;
		it.first = lead;
		it.fitness = fit;
		it.random_draw = draw;
		return it;
	endfunction

	function automatic logic [FIT_W-1:0] pick_fitness(fit_style_e style);
		case (style)
			FIT_SMALL: return FIT_W'($urandom_range(0, 3));
			FIT_HIGH:  return $urandom_range(0, 1) ? {FIT_W{1'b1}}
				: FIT_W'($urandom_range(16'hFF00, 16'hFFFF));
			FIT_ZERO:  return '0;
			default:   return FIT_W'($urandom);
		endcase
	endfunction

	// Draws lean on both ends of the range.
	function automatic logic [DRAW_W-1:0] pick_draw();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return {DRAW_W{1'b1}};
		return DRAW_W'($urandom);
	endfunction

	// The first settings hit the extremes, later ones are mostly small populations.
	function automatic logic [POP_W-1:0] pick_pop_size(int unsigned phase);
		case (phase)
			0: return POP_W'(2);
			1: return POP_W'(64);
			2: return POP_W'(127);
			3: return POP_W'(0);
			4: return POP_W'(1);
			5: return POP_W'(65);
			default: begin
				if ($urandom_range(0, 4) == 0) return POP_W'($urandom_range(0, 127));
				return POP_W'($urandom_range(2, 12));
			end
		endcase
	endfunction

	// Sender gap before an item, unless the run is in its quiet tail.
	task automatic idle_burst();
		calm = tracker.accepted >= calm_mark;
		if (!calm && tx_bursts && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Presents one item and returns at the edge where it is taken.
	task automatic push_item(in_item_t it);
		idle_burst();
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic push_select(logic [DRAW_W-1:0] draw);
		push_item(pack_item(REQ_SELECT, 1'($urandom_range(0, 1)), FIT_W'($urandom), draw));
	endtask

	task automatic push_load(logic lead, logic [FIT_W-1:0] fit);
		push_item(pack_item(REQ_LOAD, lead, fit, DRAW_W'($urandom)));
	endtask

	// Waits until every selection has come out and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.picks_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write: setup phase, then access phase.
	task automatic write_pop(logic [POP_W-1:0] value);
		logic [31:0] word;
		word = $urandom;
		if ($urandom_range(0, 1)) word = '0;
		word[POP_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_POP_SIZE;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.set_pop(value);
	endtask

	// One generation: a load sequence, sometimes broken, then a few selections.
	task automatic run_generation(int unsigned n);
		fit_style_e  style;
		seq_shape_e  shape;
		int unsigned r;
		int unsigned len;
		bit          lead;
		tx_bursts = $urandom_range(0, 2) != 0;
		r = $urandom_range(0, 9);
		if (r < 2) style = FIT_SMALL;
		else if (r == 2) style = FIT_HIGH;
		else if (r == 3) style = FIT_ZERO;
		else style = FIT_FULL;
		r = $urandom_range(0, 9);
		shape = (r <= SEQ_NO_FIRST) ? seq_shape_e'(r) : SEQ_CLEAN;
		len = n;
		lead = 1'b1;
		case (shape)
			SEQ_SHORT:    len = $urandom_range(1, n - 1);
			SEQ_LONG:     len = n + $urandom_range(1, 3);
			SEQ_NO_FIRST: lead = 1'b0;
			default: ;
		endcase
		for (int i = 0; i < len; i++) begin
			push_load(lead && i == 0, pick_fitness(style));
		end
		repeat ($urandom_range(1, 6)) push_select(pick_draw());
	endtask

	// Stimulus and end of run.
	initial begin
		int unsigned goal;
		int unsigned phase;
		in_valid <= 1'b0;
		in_item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Select straight after reset, nothing loaded yet.
		push_select(16'h1234);
		settle();
		// Register value below the minimum, so two individuals.
		write_pop(POP_W'(0));
		// Load without a first mark on an empty block, then a short population.
		push_load(1'b0, 16'h0000);
		push_select(16'hFFFF);
		// A zero total, and a load past the end that is dropped.
		push_load(1'b0, 16'h0000);
		push_load(1'b0, 16'hFFFF);
		push_select(16'h8000);
		// Fresh population; draw of zero and the full draw.
		push_load(1'b1, 16'hFFFF);
		push_load(1'b0, 16'h0001);
		push_select(16'h0000);
		push_select(16'hFFFF);
		push_select(16'h7FFF);
		settle();
		// Register value above the maximum; the population is now incomplete.
		write_pop(POP_W'(127));
		push_select(16'h5555);
		settle();
		// Three individuals, the first with zero fitness.
		write_pop(POP_W'(3));
		push_load(1'b1, 16'h0000);
		push_load(1'b0, 16'h00FF);
		push_load(1'b0, 16'hFF00);
		push_select(16'h0001);
		settle();
		// Shrinking the population after loading uses the shorter total.
		write_pop(POP_W'(2));
		push_select(16'hFFFF);
		push_select(16'h8000);
		push_load(1'b0, 16'h0005);
		push_select(16'hAAAA);

		// Random phases, each under its own register setting.
		goal = tracker.accepted + ITEM_GOAL;
		calm_mark = goal - ITEM_GOAL / 10;
		phase = 0;
		while (tracker.accepted < goal) begin
			settle();
			write_pop(pick_pop_size(phase));
			// Selections against whatever table the last setting left behind.
			repeat ($urandom_range(0, 2)) push_select(pick_draw());
			repeat ($urandom_range(2, 4)) begin
				if (tracker.accepted < goal) run_generation(tracker.pop_in_use());
			end
			phase++;
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.picks_due.size() != 0) begin
			$error("%0d selections never came out", tracker.picks_due.size());
			tracker.errors++;
		end
		$display("Covered %0d items over %0d pop_size settings: %0d fitness values stored.",
			tracker.accepted, tracker.pop_writes, tracker.loads);
		$display("Selections: %0d picked, %0d with zero total, %0d on an incomplete population.",
			tracker.picks_ok, tracker.picks_zero, tracker.picks_short);
		if (tracker.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: roulette_wheel_selector.f
src/rws_pkg.sv
src/rws_cell.sv
src/roulette_wheel_selector.sv
dv/tb_top.sv
